>>> sv/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OCC_W     = 5;
    localparam int unsigned CAPACITY_DEFAULT = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // operation codes carried on s_tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } spq_cmd_t;

endpackage

>>> sv/sorted_priority_queue.sv
// sorted priority queue: a chain of compare-and-shift cells with a registered result
// an accepted input transaction shows its result on m_tvalid in the next cycle
// one item per cycle while no result stalls; every cell compares the new value in parallel
// the output register is refilled in the cycle its result is taken, so no bubble
// reset: synchronous active-low aresetn empties the queue and clears m_tvalid
// cell contents are not reset; only entries below the occupancy count are ever read
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_in
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [33:2] value_out, [38:34] occupancy
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [39:0]      m_tdata_reg;
    logic [39:0]      m_tdata_next;

    logic             accept;
    logic             full;
    logic             empty;
    spq_cmd_t         cmd;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value_out;

    logic signed [DATA_W-1:0] entries [CAPACITY];
    logic                     lts     [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign cmd.ins   = accept && (s_tuser == KIND_INSERT) && !full;
    assign cmd.pop   = accept && (s_tuser == KIND_REMOVE) && !empty;
    assign cmd.value = s_tdata;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic                     prev_lt;
            logic signed [DATA_W-1:0] prev_entry;
            logic signed [DATA_W-1:0] next_entry;

            if (i == 0) begin : g_head
                assign prev_lt    = 1'b1;
                assign prev_entry = cmd.value;
            end else begin : g_body
                assign prev_lt    = lts[i-1];
                assign prev_entry = entries[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign next_entry = entries[i];
            end else begin : g_inner
                assign next_entry = entries[i+1];
            end

            spq_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .occupied   (count_reg > CNT_W'(i)),
                .prev_lt    (prev_lt),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .entry      (entries[i]),
                .lt         (lts[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        status     = STATUS_DONE;
        value_out  = '0;
        if (s_tuser == KIND_INSERT) begin
            if (full) begin
                status = STATUS_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status = STATUS_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
                value_out  = entries[0];
            end
        end
        if (!accept) begin
            count_next = count_reg;
        end
    end

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tdata_next  = {1'b0, OCC_W'(count_next), value_out, status};
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/spq_cell.sv
// one storage cell of the sorted chain: compares, keeps, takes the new value, or takes from a neighbour
module spq_cell (
    input  logic                             aclk,
    input  spq_pkg::spq_cmd_t                cmd,
    input  logic                             occupied,
    input  logic                             prev_lt,
    input  logic signed [spq_pkg::DATA_W-1:0] prev_entry,
    input  logic signed [spq_pkg::DATA_W-1:0] next_entry,
    output logic signed [spq_pkg::DATA_W-1:0] entry,
    output logic                             lt
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    assign entry = entry_reg;
    // stored entries form an ascending prefix, so lt is true for a prefix of the chain
    assign lt    = occupied && (entry_reg < cmd.value);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (lt) begin
                entry_next = entry_reg;
            end else if (prev_lt) begin
                entry_next = cmd.value;
            end else begin
                entry_next = prev_entry;
            end
        end else if (cmd.pop) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> sv/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import spq_pkg::*;

    // a stalled result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted transaction yields a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction gave no result");

    // the output register never blocks input once it is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // a refused operation returns zero and a defined status
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STATUS_DONE) |->
            (m_tdata[33:2] == 32'd0) &&
            ((m_tdata[1:0] == STATUS_FULL) || (m_tdata[1:0] == STATUS_EMPTY)))
        else $error("refused operation returned data or bad status");

    // an empty-refusal means the occupancy is zero
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == STATUS_EMPTY) |-> m_tdata[38:34] == 5'd0)
        else $error("empty refusal with nonzero occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
